// ----- hdl/plt_pkg.sv -----
// shared types and constants for the positional list table
// used by plt_cell, plt_chain and positional_list_table
package plt_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int REQ_W    = 3;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_FIELDS_W = REQ_W + POS_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + DATA_W + POS_W + POS_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_GET    = 3'd2,
        REQ_LOCATE = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_e_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- hdl/plt_cell.sv -----
// one list slot: holds an entry, shifts with its neighbors, compares and reads
// depends on plt_pkg
module plt_cell (
    input  logic                           aclk,
    input  plt_pkg::cell_cmd_t             cmd,
    input  logic [plt_pkg::IDX_W-1:0]      index,
    input  logic [plt_pkg::DATA_W-1:0]     left_entry,
    input  logic [plt_pkg::DATA_W-1:0]     right_entry,
    output logic [plt_pkg::DATA_W-1:0]     entry,
    output logic [plt_pkg::DATA_W-1:0]     read_data,
    output logic                           match
);

    logic [plt_pkg::DATA_W-1:0] entry_reg;
    logic [plt_pkg::DATA_W-1:0] entry_next;
    logic                       at_idx;
    logic                       above_idx;

    assign at_idx    = (index == cmd.idx);
    assign above_idx = (index > cmd.idx);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins && above_idx) begin
            entry_next = left_entry;
        end else if (cmd.ins && at_idx) begin
            entry_next = cmd.value;
        end else if (cmd.del && (at_idx || above_idx)) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign read_data = at_idx ? entry_reg : '0;
    // only slots below the fill count take part in a search
    assign match     = (plt_pkg::CNT_W'(index) < cmd.count) && (entry_reg == cmd.value);

endmodule

// ----- hdl/plt_chain.sv -----
// row of list slots wired to their neighbors, with read gather and match vector
// depends on plt_pkg and plt_cell
module plt_chain (
    input  logic                           aclk,
    input  plt_pkg::cell_cmd_t             cmd,
    output logic [plt_pkg::DATA_W-1:0]     read_data,
    output logic [plt_pkg::CAPACITY-1:0]   match_vec
);

    logic [plt_pkg::DATA_W-1:0] entry_w [plt_pkg::CAPACITY];
    logic [plt_pkg::DATA_W-1:0] read_w  [plt_pkg::CAPACITY];

    for (genvar i = 0; i < plt_pkg::CAPACITY; i++) begin : g_cell
        logic [plt_pkg::DATA_W-1:0] left_w;
        logic [plt_pkg::DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = cmd.value;
        end else begin : g_mid
            assign left_w = entry_w[i-1];
        end

        // the top slot keeps its own entry on a delete
        if (i == plt_pkg::CAPACITY - 1) begin : g_last
            assign right_w = entry_w[i];
        end else begin : g_inner
            assign right_w = entry_w[i+1];
        end

        plt_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .index       (plt_pkg::IDX_W'(i)),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .read_data   (read_w[i]),
            .match       (match_vec[i])
        );
    end

    always_comb begin
        read_data = '0;
        for (int i = 0; i < plt_pkg::CAPACITY; i++) begin
            read_data = read_data | read_w[i];
        end
    end

endmodule

// ----- hdl/positional_list_table.sv -----
// top level of the positional list table: request decode, fill count,
// result stage and stream handshakes; depends on plt_pkg and plt_chain
//
// Ordered list of up to 32 signed words held in a row of slot cells; insert
// and delete shift the slots from the given position upward together. One
// item is taken per cycle while the result stage drains; the accepting edge
// updates the cells and registers the read word and their match bits in the
// middle stage, and the advance out of it priority-encodes the match bits for
// locate into the result register that drives m_tdata. A result held by a low
// m_tready keeps one more item in the middle stage, after which s_tready drops.
// Nothing needs clearing after reset; slots past the fill count are never read.
module positional_list_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // req_type[2:0], position[8:3], value_in[40:9], zero fill above
    input  logic [plt_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[0], value_out[32:1], found_position[38:33], list_length[44:39],
    // is_empty[45], zero fill above
    output logic [plt_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                           accept;
    logic                           advance;
    logic [plt_pkg::REQ_W-1:0]      req;
    logic [plt_pkg::POS_W-1:0]      pos;
    logic [plt_pkg::DATA_W-1:0]     val;
    logic [plt_pkg::CMP_W-1:0]      pos_c;
    logic [plt_pkg::CMP_W-1:0]      cnt_c;
    logic                           ins_ok;
    logic                           rd_ok;
    logic                           err;
    logic                           is_locate;
    logic                           do_ins;
    logic                           do_del;
    logic                           do_read;
    plt_pkg::cell_cmd_t             cmd;
    logic [plt_pkg::DATA_W-1:0]     read_data;
    logic [plt_pkg::CAPACITY-1:0]   match_vec;

    logic [plt_pkg::CNT_W-1:0]      count_reg, count_next;

    logic                           p_valid_reg, p_valid_next;
    logic                           p_err_reg;
    logic                           p_locate_reg;
    logic [plt_pkg::DATA_W-1:0]     p_vout_reg;
    logic [plt_pkg::CAPACITY-1:0]   p_match_reg;
    logic [plt_pkg::CNT_W-1:0]      p_len_reg;

    logic                           m_valid_reg, m_valid_next;
    logic [plt_pkg::M_TDATA_W-1:0]  m_data_reg;
    logic [plt_pkg::POS_W-1:0]      found;

    assign req = s_tdata[plt_pkg::REQ_W-1:0];
    assign pos = s_tdata[plt_pkg::REQ_W +: plt_pkg::POS_W];
    assign val = s_tdata[plt_pkg::REQ_W + plt_pkg::POS_W +: plt_pkg::DATA_W];

    assign advance  = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign pos_c  = plt_pkg::CMP_W'(pos);
    assign cnt_c  = plt_pkg::CMP_W'(count_reg);
    assign ins_ok = (cnt_c < plt_pkg::CMP_W'(plt_pkg::CAPACITY)) && (pos_c != '0)
                    && (pos_c <= cnt_c + plt_pkg::CMP_W'(1));
    assign rd_ok  = (pos_c != '0) && (pos_c <= cnt_c);

    always_comb begin
        err        = 1'b0;
        is_locate  = 1'b0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_read    = 1'b0;
        count_next = count_reg;
        unique case (req)
            plt_pkg::REQ_INSERT: begin
                err    = !ins_ok;
                do_ins = ins_ok;
                if (ins_ok) begin
                    count_next = count_reg + plt_pkg::CNT_W'(1);
                end
            end
            plt_pkg::REQ_DELETE: begin
                err     = !rd_ok;
                do_del  = rd_ok;
                do_read = rd_ok;
                if (rd_ok) begin
                    count_next = count_reg - plt_pkg::CNT_W'(1);
                end
            end
            plt_pkg::REQ_GET: begin
                err     = !rd_ok;
                do_read = rd_ok;
            end
            plt_pkg::REQ_LOCATE: begin
                is_locate = 1'b1;
            end
            plt_pkg::REQ_CLEAR: begin
                count_next = '0;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    always_comb begin
        cmd.ins   = accept && do_ins;
        cmd.del   = accept && do_del;
        cmd.idx   = plt_pkg::IDX_W'(pos - plt_pkg::POS_W'(1));
        cmd.count = count_reg;
        cmd.value = val;
    end

    plt_chain u_chain (
        .aclk      (aclk),
        .cmd       (cmd),
        .read_data (read_data),
        .match_vec (match_vec)
    );

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (advance) begin
            p_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_err_reg    <= err;
            p_locate_reg <= is_locate;
            p_vout_reg   <= do_read ? read_data : '0;
            p_match_reg  <= match_vec;
            p_len_reg    <= count_next;
        end
    end

    // lowest matching slot wins
    always_comb begin
        found = '0;
        for (int i = plt_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (p_match_reg[i]) begin
                found = plt_pkg::POS_W'(i + 1);
            end
        end
        if (!p_locate_reg) begin
            found = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= plt_pkg::M_TDATA_W'({
                (p_len_reg == '0),
                plt_pkg::POS_W'(p_len_reg),
                found,
                p_vout_reg,
                p_err_reg
            });
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- dv/plt_checker.sv -----
// result checker for the positional list table: keeps its own copy of the list,
// predicts one result per accepted request and compares it with the m_ stream
// depends on plt_pkg
module plt_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // req_type[2:0], position[8:3], value_in[40:9], zero fill above
    input  logic [plt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // status[0], value_out[32:1], found_position[38:33], list_length[44:39],
    // is_empty[45], zero fill above
    input  logic [plt_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending
);

    // declared from the top bit down, so it matches the m_tdata layout
    typedef struct packed {
        logic                       is_empty;
        logic [plt_pkg::POS_W-1:0]  list_length;
        logic [plt_pkg::POS_W-1:0]  found_position;
        logic [plt_pkg::DATA_W-1:0] value_out;
        logic                       status;
    } list_result_t;

    logic [plt_pkg::DATA_W-1:0] list_slots [plt_pkg::CAPACITY];
    int                         list_fill;
    list_result_t               expected_results [$];

    // updates the local list and returns the result the request should give
    function automatic list_result_t apply_request(logic [plt_pkg::REQ_W-1:0] req,
                                                   logic [plt_pkg::POS_W-1:0] pos,
                                                   logic [plt_pkg::DATA_W-1:0] val);
        list_result_t r;
        int           p;
        int           k;
        r = '0;
        p = int'(pos);
        case (req)
            plt_pkg::REQ_INSERT: begin
                if (list_fill >= plt_pkg::CAPACITY || p < 1 || p > list_fill + 1) begin
                    r.status = 1'b1;
                end else begin
                    for (k = list_fill; k >= p; k--)
                        list_slots[k] = list_slots[k-1];
                    list_slots[p-1] = val;
                    list_fill++;
                end
            end
            plt_pkg::REQ_DELETE: begin
                if (list_fill == 0 || p < 1 || p > list_fill) begin
                    r.status = 1'b1;
                end else begin
                    r.value_out = list_slots[p-1];
                    for (k = p; k < list_fill; k++)
                        list_slots[k-1] = list_slots[k];
                    list_fill--;
                end
            end
            plt_pkg::REQ_GET: begin
                if (list_fill == 0 || p < 1 || p > list_fill)
                    r.status = 1'b1;
                else
                    r.value_out = list_slots[p-1];
            end
            plt_pkg::REQ_LOCATE: begin
                for (k = 0; k < list_fill; k++) begin
                    if (list_slots[k] == val) begin
                        r.found_position = plt_pkg::POS_W'(k + 1);
                        break;
                    end
                end
            end
            plt_pkg::REQ_CLEAR: begin
                list_fill = 0;
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        r.list_length = plt_pkg::POS_W'(list_fill);
        r.is_empty    = (list_fill == 0);
        return r;
    endfunction

    task automatic compare_result(list_result_t got);
        list_result_t want;
        if (expected_results.size() == 0) begin
            $error("result item with none expected: %h", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.value_out !== want.value_out) begin
            $error("value_out: expected %0d, got %0d",
                   $signed(want.value_out), $signed(got.value_out));
            fail_count++;
        end
        if (got.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, got.found_position);
            fail_count++;
        end
        if (got.list_length !== want.list_length) begin
            $error("list_length: expected %0d, got %0d",
                   want.list_length, got.list_length);
            fail_count++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
        list_fill  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            list_fill = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                compare_result(list_result_t'(m_tdata[plt_pkg::M_FIELDS_W-1:0]));
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(
                    s_tdata[plt_pkg::REQ_W-1:0],
                    s_tdata[plt_pkg::REQ_W +: plt_pkg::POS_W],
                    s_tdata[plt_pkg::REQ_W + plt_pkg::POS_W +: plt_pkg::DATA_W]));
        end
        pending = expected_results.size();
    end

endmodule

// ----- dv/positional_list_table_test.sv -----
// testbench top for the positional list table: clock, reset, request stimulus,
// random ready stalls and the verdict; depends on plt_pkg, plt_checker, the rtl
module positional_list_table_test;

    localparam int REQ_CODE_MAX  = (1 << plt_pkg::REQ_W) - 1;
    localparam int POS_MAX       = (1 << plt_pkg::POS_W) - 1;
    localparam int NUM_PHASES    = 15;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PHASE_FILL    = 0;
    localparam int PHASE_DRAIN   = 1;
    localparam int PHASE_MIXED   = 2;
    localparam int HOLD_PHASE    = 3;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [plt_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [plt_pkg::M_TDATA_W-1:0] m_tdata;

    int chk_fail;
    int chk_pending;
    int idle_cycles;
    int fill_est;
    bit tx_gaps_on;
    bit rx_always;
    bit hold_request;

    positional_list_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    plt_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (chk_fail),
        .pending    (chk_pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // a small pool of values gives locate hits and duplicate entries
    function automatic logic [plt_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'h0000_0001;
            5:       return 32'h5555_5555;
            6:       return 32'haaaa_aaaa;
            default: return 32'h1234_5678;
        endcase
    endfunction

    function automatic logic [plt_pkg::POS_W-1:0] pick_position(
        logic [plt_pkg::REQ_W-1:0] req);
        if ($urandom_range(0, 99) >= 80)
            return plt_pkg::POS_W'($urandom_range(0, POS_MAX));
        if (req == plt_pkg::REQ_INSERT)
            return plt_pkg::POS_W'($urandom_range(1, fill_est + 1));
        return plt_pkg::POS_W'($urandom_range(1, (fill_est > 0) ? fill_est : 1));
    endfunction

    function automatic logic [plt_pkg::REQ_W-1:0] pick_request(int kind);
        int r;
        int t_ins;
        int t_del;
        int t_get;
        int t_loc;
        int t_clr;
        r = $urandom_range(0, 99);
        case (kind)
            PHASE_FILL: begin
                t_ins = 70; t_del = 80; t_get = 88; t_loc = 96; t_clr = 97;
            end
            PHASE_DRAIN: begin
                t_ins = 15; t_del = 75; t_get = 85; t_loc = 95; t_clr = 96;
            end
            default: begin
                t_ins = 35; t_del = 60; t_get = 75; t_loc = 93; t_clr = 96;
            end
        endcase
        if (r < t_ins) return plt_pkg::REQ_INSERT;
        if (r < t_del) return plt_pkg::REQ_DELETE;
        if (r < t_get) return plt_pkg::REQ_GET;
        if (r < t_loc) return plt_pkg::REQ_LOCATE;
        if (r < t_clr) return plt_pkg::REQ_CLEAR;
        return plt_pkg::REQ_W'($urandom_range(int'(plt_pkg::REQ_CLEAR) + 1, REQ_CODE_MAX));
    endfunction

    // offers one item and returns once it is accepted; tracks the list length
    task automatic send_request(logic [plt_pkg::REQ_W-1:0] req,
                                logic [plt_pkg::POS_W-1:0] pos,
                                logic [plt_pkg::DATA_W-1:0] val);
        int gap;
        gap = tx_gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= plt_pkg::S_TDATA_W'({val, pos, req});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (req)
            plt_pkg::REQ_INSERT:
                if (fill_est < plt_pkg::CAPACITY && pos >= 1 && pos <= fill_est + 1)
                    fill_est++;
            plt_pkg::REQ_DELETE:
                if (pos >= 1 && pos <= fill_est)
                    fill_est--;
            plt_pkg::REQ_CLEAR:
                fill_est = 0;
            default: ;
        endcase
    endtask

    // receiver: random ready runs, always-ready stretches, one long hold-off
    initial begin
        int run;
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_always) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) < 70);
                run = 1 + gap_len();
                repeat (run) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** positional_list_table: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        int code;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        fill_est     = 0;
        tx_gaps_on   = 1'b1;
        rx_always    = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, both value extremes, all request codes
        send_request(plt_pkg::REQ_GET,    plt_pkg::POS_W'(1),       32'h0000_0000);
        send_request(plt_pkg::REQ_DELETE, plt_pkg::POS_W'(1),       32'h0000_0000);
        send_request(plt_pkg::REQ_LOCATE, plt_pkg::POS_W'(0),       32'h0000_0005);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(0),       32'h1111_1111);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(2),       32'h2222_2222);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(1),       32'h8000_0000);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(2),       32'h7fff_ffff);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(1),       32'h0000_0000);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(4),       32'hffff_ffff);
        send_request(plt_pkg::REQ_INSERT, plt_pkg::POS_W'(POS_MAX), 32'h3333_3333);
        send_request(plt_pkg::REQ_LOCATE, plt_pkg::POS_W'(POS_MAX), 32'h7fff_ffff);
        send_request(plt_pkg::REQ_LOCATE, plt_pkg::POS_W'(1),       32'h0001_2345);
        send_request(plt_pkg::REQ_GET,    plt_pkg::POS_W'(4),       32'h0000_0000);
        send_request(plt_pkg::REQ_GET,    plt_pkg::POS_W'(0),       32'h0000_0000);
        send_request(plt_pkg::REQ_GET,    plt_pkg::POS_W'(5),       32'h0000_0000);
        send_request(plt_pkg::REQ_DELETE, plt_pkg::POS_W'(2),       32'hffff_ffff);
        send_request(plt_pkg::REQ_DELETE, plt_pkg::POS_W'(0),       32'h0000_0000);
        send_request(plt_pkg::REQ_DELETE, plt_pkg::POS_W'(POS_MAX), 32'h0000_0000);
        for (code = int'(plt_pkg::REQ_CLEAR) + 1; code <= REQ_CODE_MAX; code++)
            send_request(plt_pkg::REQ_W'(code), plt_pkg::POS_W'(1), 32'hdead_beef);
        send_request(plt_pkg::REQ_CLEAR,  plt_pkg::POS_W'(0),       32'h0000_0000);
        send_request(plt_pkg::REQ_GET,    plt_pkg::POS_W'(1),       32'h0000_0000);
        send_request(plt_pkg::REQ_LOCATE, plt_pkg::POS_W'(1),       32'h0000_0000);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            kind       = (ph == 0) ? PHASE_FILL : $urandom_range(PHASE_FILL, PHASE_MIXED);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_always  = ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE) begin
                tx_gaps_on   = 1'b0;
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                logic [plt_pkg::REQ_W-1:0] req;
                req = pick_request(kind);
                send_request(req, pick_position(req), pick_value());
            end
        end
        s_tvalid <= 1'b0;
        rx_always = 1'b0;

        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (chk_fail == 0)
            $display("** positional_list_table: PASSED **");
        else
            $display("** positional_list_table: FAILED **");
        $finish;
    end

endmodule
